// ===== sv/pil_pkg.sv =====
package pil_pkg;

  // Default list capacity
  localparam int CAPACITY_DEFAULT = 64;

  // Field widths fixed by the word format
  localparam int DATA_W  = 32;
  localparam int POS_W   = 7;
  localparam int CMD_W   = 2;
  localparam int COUNT_W = 7;
  localparam int STAT_W  = 2;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

  // Status codes
  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  // Input word
  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
  } pil_item_t;

  // Result word
  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic [COUNT_W-1:0]       list_count;
    logic [STAT_W-1:0]        status;
  } pil_result_t;

  // Operation broadcast to every cell of the row
  typedef struct packed {
    logic ins;
    logic del;
    logic rd;
  } pil_cell_ctrl_t;

endpackage

// ===== sv/pil_cell.sv =====
module pil_cell #(
  parameter int IW  = 6,
  parameter int IDX = 0
) (
  input  logic                           clk,
  input  pil_pkg::pil_cell_ctrl_t        ctrl,
  input  logic [IW-1:0]                  k,
  input  logic [pil_pkg::DATA_W-1:0]     ins_value,
  input  logic [pil_pkg::DATA_W-1:0]     left_data,
  input  logic [pil_pkg::DATA_W-1:0]     right_data,
  output logic [pil_pkg::DATA_W-1:0]     data,
  output logic [pil_pkg::DATA_W-1:0]     tap
);
  import pil_pkg::*;

  localparam logic [IW-1:0] IDX_V = IW'(IDX);

  logic at_k;
  logic above_k;

  // Locate this cell relative to the addressed slot
  always_comb begin
    at_k    = (IDX_V == k);
    above_k = (IDX_V > k);
  end

  // Take the new word, shift up from the left or down from the right, else hold
  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (at_k) begin
        data <= ins_value;
      end else if (above_k) begin
        data <= left_data;
      end
    end else if (ctrl.del && (at_k || above_k)) begin
      data <= right_data;
    end
  end

  // Drive the read tap only from the addressed cell
  assign tap = (ctrl.rd && at_k) ? data : '0;

endmodule

// ===== sv/pil_or_tree.sv =====
module pil_or_tree #(
  parameter int LEAVES = 64
) (
  input  logic                                   clk,
  input  logic [LEAVES-1:0][pil_pkg::DATA_W-1:0] leaf,
  output logic [pil_pkg::DATA_W-1:0]             root
);
  import pil_pkg::*;

  // Heap-ordered nodes: node n has children 2n and 2n+1, leaves sit above LEAVES-1
  logic [DATA_W-1:0] node [1:LEAVES-1];

  for (genvar n = 1; n < LEAVES; n++) begin : g_node
    logic [DATA_W-1:0] lhs;
    logic [DATA_W-1:0] rhs;

    if (2 * n >= LEAVES) begin : g_from_leaf
      assign lhs = leaf[2 * n - LEAVES];
      assign rhs = leaf[2 * n + 1 - LEAVES];
    end else begin : g_from_node
      assign lhs = node[2 * n];
      assign rhs = node[2 * n + 1];
    end

    // Merge one level per cycle; at most one tap is live
    always_ff @(posedge clk) begin
      node[n] <= lhs | rhs;
    end
  end

  assign root = node[1];

endmodule

// ===== sv/positional_insert_delete_list.sv =====
// Ordered list of signed 32-bit words held in a row of CAPACITY cells, with its
// length. Insert at a one-based position moves that slot and everything above
// it up by one and stores the new word; delete moves everything above the slot
// down by one; read returns the word at the slot. Every input word yields one
// result word with the length after the operation and a status (done, position
// out of range, list full); a failed operation changes nothing. All cells shift
// together in the same cycle, so inserts, deletes and failed reads are taken
// one per cycle while no read is in flight and the result side keeps up. A
// successful read gathers the addressed cell through a registered OR tree of
// log2(CAPACITY) levels (rounded up) into the result register; no new word is
// taken until the read has left the tree. Entries are not cleared at reset;
// only slots below the length are ever read.
module positional_insert_delete_list #(
  parameter int CAPACITY = pil_pkg::CAPACITY_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  pil_pkg::pil_item_t   item,
  output logic                 result_valid,
  input  logic                 result_stall,
  output pil_pkg::pil_result_t result
);
  import pil_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int LW = $clog2(CAPACITY + 1);
  localparam int CW = ((LW > POS_W) ? LW : POS_W) + 1;
  localparam int P  = 2 ** IW;

  logic [LW-1:0]        length;
  logic [LW-1:0]        length_next;
  logic [IW-1:0]        rd_pipe;
  logic                 accept;
  logic                 busy;
  logic [CW-1:0]        pos_w;
  logic [CW-1:0]        len_w;
  logic                 pos_nz;
  logic                 full;
  logic [IW-1:0]        k;
  logic [STAT_W-1:0]    status_now;
  pil_cell_ctrl_t       ctrl;
  logic [DATA_W-1:0]    cell_data [CAPACITY];
  logic [P-1:0][DATA_W-1:0] taps;
  logic [DATA_W-1:0]    root;

  // Hold off new words while a read is in the tree or the result is blocked
  assign busy       = |rd_pipe;
  assign item_stall = busy || (result_valid && result_stall);
  assign accept     = item_valid && !item_stall;

  // Decode the command and check the position against the length
  always_comb begin
    pos_w       = CW'(item.position);
    len_w       = CW'(length);
    pos_nz      = (item.position != '0);
    full        = (length == LW'(CAPACITY));
    k           = IW'(item.position - POS_W'(1));
    ctrl        = '0;
    status_now  = ST_RANGE;
    length_next = length;
    unique case (item.cmd)
      CMD_INSERT: begin
        if (pos_nz && (pos_w <= len_w + CW'(1))) begin
          if (full) begin
            status_now = ST_FULL;
          end else begin
            ctrl.ins    = accept;
            length_next = length + LW'(1);
            status_now  = ST_DONE;
          end
        end
      end
      CMD_DELETE: begin
        if (pos_nz && (pos_w <= len_w)) begin
          ctrl.del    = accept;
          length_next = length - LW'(1);
          status_now  = ST_DONE;
        end
      end
      CMD_READ: begin
        if (pos_nz && (pos_w <= len_w)) begin
          ctrl.rd    = accept;
          status_now = ST_DONE;
        end
      end
      default: begin
        status_now = ST_RANGE;
      end
    endcase
  end

  // Row of cells, each linked to both neighbours
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left_data;
    logic [DATA_W-1:0] right_data;

    if (i == 0) begin : g_first
      assign left_data = '0;
    end else begin : g_left
      assign left_data = cell_data[i - 1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_data = '0;
    end else begin : g_right
      assign right_data = cell_data[i + 1];
    end

    pil_cell #(
      .IW  (IW),
      .IDX (i)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .k          (k),
      .ins_value  (item.value),
      .left_data  (left_data),
      .right_data (right_data),
      .data       (cell_data[i]),
      .tap        (taps[i])
    );
  end

  // Pad the tree up to a power of two
  for (genvar j = CAPACITY; j < P; j++) begin : g_pad
    assign taps[j] = '0;
  end

  pil_or_tree #(
    .LEAVES (P)
  ) u_tree (
    .clk  (clk),
    .leaf (taps),
    .root (root)
  );

  // Track the length and the read in flight; load or drain the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      length       <= '0;
      rd_pipe      <= '0;
      result_valid <= 1'b0;
    end else begin
      if (accept) begin
        length <= length_next;
      end
      rd_pipe <= IW'({rd_pipe, ctrl.rd});
      if (rd_pipe[IW-1] || (accept && !ctrl.rd)) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (rd_pipe[IW-1]) begin
      result.read_value <= root;
      result.list_count <= COUNT_W'(length);
      result.status     <= ST_DONE;
    end else if (accept && !ctrl.rd) begin
      result.read_value <= '0;
      result.list_count <= COUNT_W'(length_next);
      result.status     <= status_now;
    end
  end

endmodule

// ===== sv/pil_checker.sv =====
module pil_checker #(
  parameter int CAPACITY = pil_pkg::CAPACITY_DEFAULT
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 item_valid,
  input logic                 item_stall,
  input pil_pkg::pil_item_t   item,
  input logic                 result_valid,
  input logic                 result_stall,
  input pil_pkg::pil_result_t result
);
  import pil_pkg::*;

  // A stalled input word holds
  a_item_hold: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_stall |=> item_valid && $stable(item))
    else $error("input word changed while stalled");

  // A blocked result word holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result word changed while stalled");

  // Only a successful read carries a value
  a_value_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.status != ST_DONE) |-> result.read_value == '0)
    else $error("failed operation returned a value");

  // A full report comes only with a full list
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.status == ST_FULL) |-> result.list_count == COUNT_W'(CAPACITY))
    else $error("list full reported below capacity");

  // The length never passes the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (CAPACITY > 127) || (result.list_count <= COUNT_W'(CAPACITY)))
    else $error("list count above capacity");

endmodule

bind positional_insert_delete_list pil_checker #(
  .CAPACITY (CAPACITY)
) u_pil_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .item         (item),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

// ===== tb/sv/tb_positional_insert_delete_list.sv =====
`timescale 1ns / 1ps

module tb_positional_insert_delete_list;
  import pil_pkg::*;

  localparam int LIST_CAP = CAPACITY_DEFAULT;
  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE_CYCLES = 20;
  localparam int PHASES = 8;
  localparam int WORDS_PER_PHASE = 150;
  localparam int LONG_HOLD = 300;
  localparam int MAX_PRINTED = 40;
  // Spare command code: no operation, always reported out of range
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

  // One row of the directed table: word to send and, where typed, its result
  typedef struct packed {
    pil_item_t   word;
    logic        typed;
    pil_result_t want;
  } probe_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_stall;
  pil_item_t   item = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  pil_result_t result;

  // Side information travelling with the offered word
  logic        item_typed = 1'b0;
  pil_result_t item_want = '0;

  // Mirror of the list contents and length
  logic signed [DATA_W-1:0] list_mirror [LIST_CAP];
  int          mirror_len = 0;
  pil_result_t pending_results [$];

  int mismatches = 0;
  int results_seen = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_ask = 0;
  int hold_left = 0;

  int send_idle_tab  [PHASES] = '{0, 56, 0, 25, 0, 56, 0, 25};
  int recv_stall_tab [PHASES] = '{0, 0, 56, 25, 0, 0, 56, 25};
  int grow_tab       [PHASES] = '{90, 50, 15, 60, 50, 85, 50, 10};
  int hold_tab       [PHASES] = '{0, 0, 0, 0, LONG_HOLD, 0, 0, 0};

  // Directed words: empty list, extremes of value and position, shifts both ways
  probe_t probes [25] = '{
    '{'{CMD_READ,   7'd1,   32'sd0},        1'b1, '{32'sd0, 7'd0, ST_RANGE}},
    '{'{CMD_DELETE, 7'd1,   32'sd0},        1'b1, '{32'sd0, 7'd0, ST_RANGE}},
    '{'{CMD_INSERT, 7'd0,   32'sd5},        1'b1, '{32'sd0, 7'd0, ST_RANGE}},
    '{'{CMD_INSERT, 7'd2,   32'sd5},        1'b1, '{32'sd0, 7'd0, ST_RANGE}},
    '{'{CMD_SPARE,  7'd1,   32'sd9},        1'b1, '{32'sd0, 7'd0, ST_RANGE}},
    '{'{CMD_INSERT, 7'd1,   32'h7fffffff},  1'b1, '{32'sd0, 7'd1, ST_DONE}},
    '{'{CMD_INSERT, 7'd1,   32'h80000000},  1'b1, '{32'sd0, 7'd2, ST_DONE}},
    '{'{CMD_INSERT, 7'd3,   32'hffffffff},  1'b1, '{32'sd0, 7'd3, ST_DONE}},
    '{'{CMD_INSERT, 7'd2,   32'h12345678},  1'b0, '0},
    '{'{CMD_READ,   7'd1,   32'sd0},        1'b1, '{32'h80000000, 7'd4, ST_DONE}},
    '{'{CMD_READ,   7'd4,   32'sd0},        1'b1, '{32'hffffffff, 7'd4, ST_DONE}},
    '{'{CMD_READ,   7'd5,   32'sd0},        1'b1, '{32'sd0, 7'd4, ST_RANGE}},
    '{'{CMD_READ,   7'd2,   32'sd0},        1'b0, '0},
    '{'{CMD_INSERT, 7'd127, 32'sd1},        1'b1, '{32'sd0, 7'd4, ST_RANGE}},
    '{'{CMD_INSERT, 7'd6,   32'sd1},        1'b1, '{32'sd0, 7'd4, ST_RANGE}},
    '{'{CMD_DELETE, 7'd1,   32'sd0},        1'b1, '{32'sd0, 7'd3, ST_DONE}},
    '{'{CMD_DELETE, 7'd3,   32'sd0},        1'b1, '{32'sd0, 7'd2, ST_DONE}},
    '{'{CMD_DELETE, 7'd3,   32'sd0},        1'b1, '{32'sd0, 7'd2, ST_RANGE}},
    '{'{CMD_READ,   7'd0,   32'sd0},        1'b1, '{32'sd0, 7'd2, ST_RANGE}},
    '{'{CMD_SPARE,  7'd127, 32'hffffffff},  1'b1, '{32'sd0, 7'd2, ST_RANGE}},
    '{'{CMD_READ,   7'd2,   32'sd0},        1'b0, '0},
    '{'{CMD_DELETE, 7'd1,   32'sd0},        1'b0, '0},
    '{'{CMD_READ,   7'd1,   32'sd0},        1'b0, '0},
    '{'{CMD_DELETE, 7'd1,   32'sd0},        1'b1, '{32'sd0, 7'd0, ST_DONE}},
    '{'{CMD_READ,   7'd64,  32'sd0},        1'b1, '{32'sd0, 7'd0, ST_RANGE}}
  };

  positional_insert_delete_list #(
    .CAPACITY(LIST_CAP)
  ) uut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Apply one word to the mirror and return the result it should give
  function automatic pil_result_t apply_to_mirror(pil_item_t w);
    pil_result_t r;
    int p;
    r = '0;
    r.status = ST_RANGE;
    p = w.position;
    case (w.cmd)
      CMD_INSERT: begin
        if (p >= 1 && p <= mirror_len + 1) begin
          if (mirror_len >= LIST_CAP) begin
            r.status = ST_FULL;
          end else begin
            for (int k = mirror_len; k > p - 1; k--) list_mirror[k] = list_mirror[k - 1];
            list_mirror[p - 1] = w.value;
            mirror_len++;
            r.status = ST_DONE;
          end
        end
      end
      CMD_DELETE: begin
        if (p >= 1 && p <= mirror_len) begin
          for (int k = p - 1; k + 1 < mirror_len; k++) list_mirror[k] = list_mirror[k + 1];
          mirror_len--;
          r.status = ST_DONE;
        end
      end
      CMD_READ: begin
        if (p >= 1 && p <= mirror_len) begin
          r.read_value = list_mirror[p - 1];
          r.status = ST_DONE;
        end
      end
      default: begin
      end
    endcase
    r.list_count = COUNT_W'(mirror_len);
    return r;
  endfunction

  // Build a random word, mostly well-formed for the current length
  function automatic pil_item_t pick_word(int grow_pct);
    pil_item_t w;
    int sel;
    int lim;
    sel = $urandom_range(0, 99);
    if (sel < 4) w.cmd = CMD_SPARE;
    else if (sel < 29) w.cmd = CMD_READ;
    else if ($urandom_range(0, 99) < grow_pct) w.cmd = CMD_INSERT;
    else w.cmd = CMD_DELETE;
    lim = (w.cmd == CMD_INSERT) ? mirror_len + 1 : mirror_len;
    sel = $urandom_range(0, 99);
    if (sel < 6) w.position = POS_W'($urandom_range(0, 127));
    else if (sel < 9) w.position = '0;
    else if (sel < 13) w.position = POS_W'(lim + 1);
    else w.position = POS_W'($urandom_range(1, (lim < 1) ? 1 : lim));
    case ($urandom_range(0, 39))
      0: w.value = 32'h7fffffff;
      1: w.value = 32'h80000000;
      2: w.value = 32'h00000000;
      3: w.value = 32'hffffffff;
      default: w.value = $urandom;
    endcase
    return w;
  endfunction

  task automatic note_mismatch(string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTED) $display("ERROR: %s", msg);
  endtask

  // Offer one word at the falling edge, after any random idle, and hold until taken
  task automatic offer(pil_item_t w, logic typed, pil_result_t want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item <= w;
    item_typed <= typed;
    item_want <= want;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall !== 1'b0);
    @(negedge clk);
  endtask

  // Stop sending, wait for every pending word, then switch the idling mix
  task automatic set_phase(int send_pct, int recv_pct, int hold);
    item_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    @(posedge clk);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    hold_ask = hold;
    @(negedge clk);
  endtask

  // Drive the result stall: long hold-off when asked, otherwise random
  always @(negedge clk) begin
    if (hold_ask > 0) begin
      hold_left = hold_ask;
      hold_ask = 0;
    end
    if (hold_left > 0) begin
      result_stall <= 1'b1;
      hold_left--;
    end else begin
      result_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Check taken results against the oldest expectation, then record taken words
  always @(posedge clk) begin
    pil_result_t predicted;
    pil_result_t want;
    if (!rst) begin
      if (result_valid && !result_stall) begin
        if (pending_results.size() == 0) begin
          note_mismatch($sformatf("result %0d with nothing pending", results_seen));
        end else begin
          want = pending_results.pop_front();
          if (result.read_value !== want.read_value)
            note_mismatch($sformatf("result %0d read_value %0d, expected %0d",
                                    results_seen, result.read_value, want.read_value));
          if (result.list_count !== want.list_count)
            note_mismatch($sformatf("result %0d list_count %0d, expected %0d",
                                    results_seen, result.list_count, want.list_count));
          if (result.status !== want.status)
            note_mismatch($sformatf("result %0d status %0d, expected %0d",
                                    results_seen, result.status, want.status));
        end
        results_seen++;
      end
      if (item_valid && !item_stall) begin
        predicted = apply_to_mirror(item);
        pending_results.push_back(item_typed ? item_want : predicted);
      end
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Walk the directed table with no idling
    foreach (probes[i]) offer(probes[i].word, probes[i].typed, probes[i].want);

    // Random words in phases of differing idling and growth bias
    for (int ph = 0; ph < PHASES; ph++) begin
      set_phase(send_idle_tab[ph], recv_stall_tab[ph], hold_tab[ph]);
      for (int n = 0; n < WORDS_PER_PHASE; n++) offer(pick_word(grow_tab[ph]), 1'b0, '0);
    end

    // Drain and let the pipeline settle
    item_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
